@@ sv/fba_pkg.sv @@
package fba_pkg;

	localparam int DEFAULT_MAX_BLOCKS = 255;

	localparam int IDX_W  = 8;
	localparam int BS_W   = 16;
	localparam int OFF_W  = 24;
	localparam int CMD_W  = 2;
	localparam int ST_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FORMAT  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE_ERR = 2'd2;
	localparam logic [ST_W-1:0] ST_NONE_USED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'd1;

	localparam logic [IDX_W-1:0] NUM_BLOCKS_RESET = 8'd255;
	localparam logic [BS_W-1:0]  BLOCK_SIZE_RESET = 16'd16;

	typedef struct packed {
		logic load;
		logic exec;
		logic fmt_step;
		logic fmt_finish;
	} fba_ctl_t;

	typedef struct packed {
		logic is_format;
		logic fmt_empty;
		logic fmt_last;
	} fba_stat_t;

endpackage

@@ sv/fba_ctrl.sv @@
module fba_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  fba_pkg::fba_stat_t stat,
	output fba_pkg::fba_ctl_t  ctl
);
	import fba_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FMT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.is_format && !stat.fmt_empty) begin
					state_d = S_FMT;
				end else begin
					ctl.exec = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_FMT: begin
				ctl.fmt_step = 1'b1;
				if (stat.fmt_last) begin
					ctl.fmt_finish = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_ctl_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.exec, ctl.fmt_step}))
		else $error("controller commands overlap");

	a_finish_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fmt_finish |-> ctl.fmt_step)
		else $error("format finish outside format walk");

	a_load_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> (state_q == S_EXEC))
		else $error("accepted item did not reach execute");

endmodule

@@ sv/fba_datapath.sv @@
module fba_datapath #(
	parameter int MAX_BLOCKS = fba_pkg::DEFAULT_MAX_BLOCKS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fba_pkg::fba_ctl_t             ctl,
	output fba_pkg::fba_stat_t            stat,
	input  logic [fba_pkg::CMD_W-1:0]     command,
	input  logic [fba_pkg::IDX_W-1:0]     block_index,
	input  logic                          cfg_we,
	input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          done,
	output logic [fba_pkg::ST_W-1:0]      status,
	output logic [fba_pkg::IDX_W-1:0]     granted_index,
	output logic [fba_pkg::OFF_W-1:0]     granted_offset,
	output logic                          all_free,
	output logic [fba_pkg::IDX_W-1:0]     free_blocks,
	output logic [fba_pkg::IDX_W-1:0]     used_blocks
);
	import fba_pkg::*;

	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam logic [IDX_W-1:0] MaxBlk = IDX_W'(MAX_BLOCKS);

	logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
	logic [IDX_W-1:0] link_rd_q;
	logic             link_we;
	logic [AW-1:0]    link_wa;
	logic [IDX_W-1:0] link_wd;

	logic [IDX_W-1:0] num_q;
	logic [BS_W-1:0]  bs_q;
	logic [CMD_W-1:0] cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] head_q, head_d;
	logic [IDX_W-1:0] free_q, free_d;
	logic [IDX_W-1:0] used_q, used_d;
	logic [IDX_W-1:0] pool_q, pool_d;
	logic [IDX_W-1:0] cursor_q, cursor_d;
	logic [IDX_W-1:0] n_sat;
	logic [ST_W-1:0]  st_d;
	logic [IDX_W-1:0] gidx_d;
	logic [OFF_W-1:0] goff_d;
	logic             done_q;

	assign n_sat = (num_q > MaxBlk) ? MaxBlk : num_q;

	assign stat.is_format = (cmd_q == CMD_FORMAT);
	assign stat.fmt_empty = (n_sat == '0);
	assign stat.fmt_last  = (({1'b0, cursor_q} + 9'd1) == {1'b0, n_sat});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NUM_BLOCKS_RESET;
			bs_q  <= BLOCK_SIZE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_NUM_BLOCKS) begin
				num_q <= cfg_data[IDX_W-1:0];
			end else if (cfg_index == REG_BLOCK_SIZE) begin
				bs_q <= cfg_data[BS_W-1:0];
			end
		end
	end

	always_comb begin
		head_d   = head_q;
		free_d   = free_q;
		used_d   = used_q;
		pool_d   = pool_q;
		cursor_d = cursor_q;
		st_d     = ST_OK;
		gidx_d   = '0;
		link_we  = 1'b0;
		link_wa  = idx_q[AW-1:0];
		link_wd  = head_q;
		if (ctl.load) begin
			cursor_d = '0;
		end
		if (ctl.exec) begin
			unique case (cmd_q)
				CMD_ACQUIRE: begin
					if (free_q == '0) begin
						st_d = ST_EMPTY;
					end else begin
						gidx_d = head_q;
						head_d = link_rd_q;
						free_d = free_q - 8'd1;
						used_d = used_q + 8'd1;
					end
				end
				CMD_RELEASE: begin
					if (idx_q >= pool_q) begin
						st_d = ST_RANGE_ERR;
					end else if (used_q == '0) begin
						st_d = ST_NONE_USED;
					end else begin
						link_we = 1'b1;
						head_d  = idx_q;
						free_d  = free_q + 8'd1;
						used_d  = used_q - 8'd1;
					end
				end
				CMD_FORMAT: begin
					head_d   = '0;
					free_d   = '0;
					used_d   = '0;
					pool_d   = '0;
					cursor_d = '0;
				end
				default: begin
				end
			endcase
		end
		if (ctl.fmt_step) begin
			link_we  = 1'b1;
			link_wa  = cursor_q[AW-1:0];
			link_wd  = cursor_q + 8'd1;
			cursor_d = cursor_q + 8'd1;
			if (ctl.fmt_finish) begin
				head_d = '0;
				free_d = n_sat;
				used_d = '0;
				pool_d = n_sat;
			end
		end
		goff_d = {16'd0, gidx_d} * {8'd0, bs_q};
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			link_rd_q <= link_mem[head_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			idx_q <= block_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			free_q   <= '0;
			used_q   <= '0;
			pool_q   <= '0;
			cursor_q <= '0;
			done_q   <= 1'b0;
		end else begin
			head_q   <= head_d;
			free_q   <= free_d;
			used_q   <= used_d;
			pool_q   <= pool_d;
			cursor_q <= cursor_d;
			done_q   <= ctl.exec | ctl.fmt_finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.exec | ctl.fmt_finish) begin
			status         <= st_d;
			granted_index  <= gidx_d;
			granted_offset <= goff_d;
			all_free       <= (used_d == '0);
			free_blocks    <= free_d;
			used_blocks    <= used_d;
		end
	end

	assign done = done_q;

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		IDX_W'(free_q + used_q) == pool_q)
		else $error("free and used counts do not add up to pool size");

	a_error_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status != ST_OK)) |-> (granted_index == '0 && granted_offset == '0))
		else $error("grant reported with error status");

	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two results in consecutive cycles");

endmodule

@@ sv/free_list_block_allocator_core.sv @@
// Channel   Direction  Handshake                 Payload
// command   in         start & !busy             command, block_index
// result    out        done (one cycle strobe)   status, granted_index, granted_offset,
//                                                all_free, free_blocks, used_blocks
// config    in         cfg_we                    cfg_index, cfg_data
//
// Acquire, release and unused codes: the item is accepted, the link memory read of the
// free head lands, then done pulses. A format with no blocks takes the same path.
// Format walks the link memory one entry per cycle over num_blocks entries, capped at MAX_BLOCKS.
// busy is high after acceptance until the result is registered; done rises as busy falls.
// Reset clears the counts and head and loads the register defaults; the link memory
// holds no reset state and is written only by format and release.
// The receiver cannot stall; each result is shown for exactly one cycle.
module free_list_block_allocator_core #(
	parameter int MAX_BLOCKS = fba_pkg::DEFAULT_MAX_BLOCKS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [fba_pkg::CMD_W-1:0]      command,
	input  logic [fba_pkg::IDX_W-1:0]      block_index,
	input  logic                           cfg_we,
	input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           done,
	output logic [fba_pkg::ST_W-1:0]       status,
	output logic [fba_pkg::IDX_W-1:0]      granted_index,
	output logic [fba_pkg::OFF_W-1:0]      granted_offset,
	output logic                           all_free,
	output logic [fba_pkg::IDX_W-1:0]      free_blocks,
	output logic [fba_pkg::IDX_W-1:0]      used_blocks
);
	import fba_pkg::*;

	fba_ctl_t  ctl;
	fba_stat_t stat;

	fba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	fba_datapath #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.command        (command),
		.block_index    (block_index),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.done           (done),
		.status         (status),
		.granted_index  (granted_index),
		.granted_offset (granted_offset),
		.all_free       (all_free),
		.free_blocks    (free_blocks),
		.used_blocks    (used_blocks)
	);

endmodule
